@@ src/bfjs_pkg.sv @@
`default_nettype none

package bfjs_pkg;

	// Depth of the waiting-job store.
	localparam int QUEUE_DEPTH = 8;
	localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int ID_W = 16;
	localparam int TIME_W = 24;
	localparam int LTIME_W = 25;
	localparam int LIMIT_W = 4;

	// Queue limit after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

	// Operation codes.
	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic operation;
		logic [ID_W-1:0] job_id;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
		logic [TIME_W-1:0] deadline;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0] done_id;
		logic aborted;
		logic [LTIME_W-1:0] finish_time;
		logic [LTIME_W-1:0] wait_time;
		logic last_result;
	} result_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic is_flush;
		logic [ID_W-1:0] job_id;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
		logic [TIME_W-1:0] deadline;
	} cmd_t;

endpackage

`default_nettype wire

@@ src/bfjs_front.sv @@
`default_nettype none

module bfjs_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire bfjs_pkg::item_t item,
	output logic                busy,
	output logic                cmd_valid,
	output bfjs_pkg::cmd_t      cmd,
	input  wire logic           cmd_pop
);
	import bfjs_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	// Classify the incoming beat into a command.
	always_comb begin
		cls.is_flush = (item.operation == OP_FLUSH);
		cls.job_id = item.job_id;
		cls.arrival_time = item.arrival_time;
		cls.run_length = item.run_length;
		cls.deadline = item.deadline;
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = buf_q[rd_ptr_q];

	// Two-entry command queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("command queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0) else $error("pop from empty command queue");
	a_fill_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !cmd_pop) |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("command queue level lost a push");

endmodule

`default_nettype wire

@@ src/bfjs_back.sv @@
`default_nettype none

module bfjs_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	input  wire bfjs_pkg::cmd_t                cmd,
	output logic                               cmd_pop,
	input  wire logic [bfjs_pkg::LIMIT_W-1:0]  queue_limit,
	output logic                               result_valid,
	output bfjs_pkg::result_t                  result
);
	import bfjs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_LAST  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0] job_id;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] run_length;
		logic [TIME_W-1:0] deadline;
	} entry_t;

	state_t             state_q;
	cmd_t               cur_q;
	entry_t             slot_q [QUEUE_DEPTH];
	logic [SLOT_W-1:0]  head_q;
	logic [COUNT_W-1:0] count_q;
	logic [LTIME_W-1:0] free_q;
	result_t            hold_q;
	logic               hold_vld_q;
	result_t            result_q;
	logic               result_valid_q;

	entry_t             head_e;
	logic [LTIME_W:0]   drn_sum;
	logic               drn_fits;
	logic               drn_late;
	logic [LTIME_W-1:0] dl_ext;
	logic               arr_ok;
	logic               drain_go;
	result_t            drn_res;
	logic [LTIME_W-1:0] drn_free;
	logic [LTIME_W-1:0] start_sum;
	logic               start_ok;
	logic               full;
	logic               fin_res_vld;
	logic               enq;
	result_t            fin_res;
	result_t            emit_res;
	logic [31:0]        cnt_ext;
	logic [31:0]        lim_ext;
	logic [31:0]        tail_ext;
	logic [SLOT_W-1:0]  tail;
	logic [SLOT_W-1:0]  head_nxt;

	// Delay from an arrival to a later time, clamped at zero.
	function automatic logic [LTIME_W-1:0] delay_of(input logic [LTIME_W-1:0] t,
			input logic [TIME_W-1:0] a);
		logic [LTIME_W-1:0] ax;
		ax = {1'b0, a};
		return (t >= ax) ? (t - ax) : '0;
	endfunction

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// Outcome of serving the job at the head of the queue.
	always_comb begin
		head_e = slot_q[head_q];
		dl_ext = {1'b0, head_e.deadline};
		drn_sum = {1'b0, free_q} + {2'b00, head_e.run_length};
		drn_fits = (drn_sum <= {1'b0, dl_ext});
		drn_late = (free_q > dl_ext);
		drn_res.done_id = head_e.job_id;
		drn_res.last_result = 1'b0;
		if (drn_fits) begin
			drn_res.aborted = 1'b0;
			drn_res.finish_time = drn_sum[LTIME_W-1:0];
			drn_res.wait_time = delay_of(free_q, head_e.arrival_time);
			drn_free = drn_sum[LTIME_W-1:0];
		end else if (drn_late) begin
			drn_res.aborted = 1'b1;
			drn_res.finish_time = free_q;
			drn_res.wait_time = delay_of(free_q, head_e.arrival_time);
			drn_free = free_q;
		end else begin
			drn_res.aborted = 1'b1;
			drn_res.finish_time = dl_ext;
			drn_res.wait_time = delay_of(dl_ext, head_e.arrival_time);
			drn_free = dl_ext;
		end
	end

	// Drain decision and handling of the arriving job.
	always_comb begin
		arr_ok = ({1'b0, cur_q.arrival_time} >= free_q);
		drain_go = (state_q == ST_DRAIN) && (count_q != '0) && (cur_q.is_flush || arr_ok);

		cnt_ext = 32'(count_q);
		lim_ext = (32'(queue_limit) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : 32'(queue_limit);
		full = (cnt_ext >= lim_ext);

		start_sum = {1'b0, cur_q.arrival_time} + {1'b0, cur_q.run_length};
		start_ok = !cur_q.is_flush && arr_ok && (count_q == '0);
		fin_res_vld = !cur_q.is_flush && (start_ok || full);
		enq = !cur_q.is_flush && !start_ok && !full;

		fin_res.done_id = cur_q.job_id;
		fin_res.aborted = !start_ok;
		fin_res.finish_time = start_ok ? start_sum : {1'b0, cur_q.arrival_time};
		fin_res.wait_time = '0;
		fin_res.last_result = 1'b0;

		// The held beat is the last one when nothing follows it.
		emit_res = hold_q;
		emit_res.last_result = !drain_go && !(state_q == ST_FINAL && fin_res_vld);

		tail_ext = 32'(head_q) + cnt_ext;
		tail = (tail_ext >= 32'(QUEUE_DEPTH)) ? SLOT_W'(tail_ext - 32'(QUEUE_DEPTH))
			: SLOT_W'(tail_ext);
		head_nxt = (32'(head_q) == 32'(QUEUE_DEPTH - 1)) ? '0 : head_q + SLOT_W'(1);
	end

	// Waiting-job store, written at the tail.
	always_ff @(posedge clk) begin
		if (state_q == ST_FINAL && enq) begin
			slot_q[tail] <= '{job_id: cur_q.job_id, arrival_time: cur_q.arrival_time,
				run_length: cur_q.run_length, deadline: cur_q.deadline};
		end
	end

	// Current command and result payloads.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (drain_go) begin
			hold_q <= drn_res;
		end else if (state_q == ST_FINAL && fin_res_vld) begin
			hold_q <= fin_res;
		end
		if (hold_vld_q) begin
			result_q <= emit_res;
		end
	end

	// Sequencer, queue pointers and server free time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			free_q <= '0;
			hold_vld_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_go) begin
						result_valid_q <= hold_vld_q;
						hold_vld_q <= 1'b1;
						head_q <= head_nxt;
						count_q <= count_q - COUNT_W'(1);
						free_q <= drn_free;
					end else begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					result_valid_q <= hold_vld_q;
					if (fin_res_vld) begin
						hold_vld_q <= 1'b1;
						state_q <= ST_LAST;
						if (start_ok) begin
							free_q <= start_sum;
						end
					end else begin
						hold_vld_q <= 1'b0;
						state_q <= ST_IDLE;
						if (enq) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
				end
				ST_LAST: begin
					result_valid_q <= 1'b1;
					hold_vld_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(QUEUE_DEPTH)) else $error("waiting count exceeds depth");
	a_drain_dec: assert property (@(posedge clk) disable iff (!arst_n)
		drain_go |=> count_q == $past(count_q) - COUNT_W'(1))
		else $error("drain did not consume a waiting job");
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |-> hold_vld_q) else $error("final beat missing");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_vld_q) else $error("result left behind in idle");

endmodule

`default_nettype wire

@@ src/bounded_fifo_job_server_unit.sv @@
// Flow: an accepted item enters the two-entry command queue; the back end pops it in ST_IDLE,
// drains waiting jobs in ST_DRAIN, settles the arriving job in ST_FINAL and sends its last result
// from ST_LAST when the arriving job gets a result. The serial drain of the job store limits the
// item rate; the command queue takes new items while the back end works, until busy is raised.
// Results leave one per cycle on a one-cycle strobe; the receiver cannot stall them.
// Reset (arst_n low, asynchronous): queue empty, free time zero, queue limit 3.
`default_nettype none

module bounded_fifo_job_server_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire bfjs_pkg::item_t               item,
	output logic                               result_valid,
	output bfjs_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bfjs_pkg::LIMIT_W-1:0]  cfg_data
);
	import bfjs_pkg::*;

	logic [LIMIT_W-1:0] queue_limit_q;
	logic               cmd_valid;
	cmd_t               cmd;
	logic               cmd_pop;

	assign cfg_ready = 1'b1;

	// Queue limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			queue_limit_q <= cfg_data;
		end
	end

	bfjs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	bfjs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.queue_limit  (queue_limit_q),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ dv/bounded_fifo_job_server_unit_test.sv @@
`timescale 1ns / 100ps

module bounded_fifo_job_server_unit_test;
	import bfjs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 55;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic result_valid;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// Shadow of the server: waiting jobs, free time and the queue limit.
	logic [ID_W-1:0] held_id [QUEUE_DEPTH];
	logic [TIME_W-1:0] held_arr [QUEUE_DEPTH];
	logic [TIME_W-1:0] held_run [QUEUE_DEPTH];
	logic [TIME_W-1:0] held_dl [QUEUE_DEPTH];
	int unsigned held_head = 0;
	int unsigned held_count = 0;
	logic [LTIME_W-1:0] free_at = '0;
	logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

	item_t job_feed [$];
	result_t due_results [$];
	int miscompares = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	int unsigned timeline = 0;

	bounded_fifo_job_server_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t outcome(input logic [ID_W-1:0] id, input logic ab,
			input logic [LTIME_W-1:0] fin, input logic [LTIME_W-1:0] waited);
		result_t r;
		r.done_id = id;
		r.aborted = ab;
		r.finish_time = fin;
		r.wait_time = waited;
		r.last_result = 1'b0;
		return r;
	endfunction

	// Delay from arrival to a later time; an earlier time counts as no delay.
	function automatic logic [LTIME_W-1:0] lag(input logic [LTIME_W-1:0] t,
			input logic [TIME_W-1:0] arr);
		return (t >= {1'b0, arr}) ? t - {1'b0, arr} : '0;
	endfunction

	// Take the oldest waiting job off the queue and run or abort it at the free time.
	function automatic result_t retire_head();
		int unsigned s;
		logic [LTIME_W-1:0] now;
		logic [LTIME_W:0] done_at;
		result_t r;
		s = held_head;
		now = free_at;
		held_head = (s + 1) % QUEUE_DEPTH;
		held_count--;
		done_at = {1'b0, now} + {2'b00, held_run[s]};
		if (done_at <= {2'b00, held_dl[s]}) begin
			r = outcome(held_id[s], 1'b0, done_at[LTIME_W-1:0], lag(now, held_arr[s]));
			free_at = done_at[LTIME_W-1:0];
		end else if (now > {1'b0, held_dl[s]}) begin
			r = outcome(held_id[s], 1'b1, now, lag(now, held_arr[s]));
		end else begin
			r = outcome(held_id[s], 1'b1, {1'b0, held_dl[s]},
				lag({1'b0, held_dl[s]}, held_arr[s]));
			free_at = {1'b0, held_dl[s]};
		end
		return r;
	endfunction

	// Work out every result that one accepted item causes and queue them in order.
	task automatic serve_item(input item_t it);
		result_t batch [$];
		int unsigned cap;
		int unsigned s;
		logic [LTIME_W-1:0] arr;
		logic [LTIME_W-1:0] fin;
		cap = (limit_now > QUEUE_DEPTH) ? QUEUE_DEPTH : limit_now;
		arr = {1'b0, it.arrival_time};
		if (it.operation == OP_FLUSH) begin
			while (held_count > 0 && batch.size() < QUEUE_DEPTH)
				batch = {batch, retire_head()};
		end else begin
			while (arr >= free_at && held_count > 0 && batch.size() < QUEUE_DEPTH)
				batch = {batch, retire_head()};
			if (arr >= free_at && held_count == 0) begin
				fin = arr + {1'b0, it.run_length};
				batch = {batch, outcome(it.job_id, 1'b0, fin, '0)};
				free_at = fin;
			end else if (held_count >= cap) begin
				batch = {batch, outcome(it.job_id, 1'b1, arr, '0)};
			end else begin
				s = (held_head + held_count) % QUEUE_DEPTH;
				held_id[s] = it.job_id;
				held_arr[s] = it.arrival_time;
				held_run[s] = it.run_length;
				held_dl[s] = it.deadline;
				held_count++;
			end
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last_result = 1'b1;
		due_results = {due_results, batch};
	endtask

	// Append one item to the pending feed.
	function automatic void queue_item(input item_t it);
		job_feed = {job_feed, it};
	endfunction

	function automatic item_t job(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
			input logic [TIME_W-1:0] run, input logic [TIME_W-1:0] dl);
		item_t it;
		it.operation = OP_ARRIVE;
		it.job_id = id;
		it.arrival_time = arr;
		it.run_length = run;
		it.deadline = dl;
		return it;
	endfunction

	// A flush carries junk in its other fields, which the block must ignore.
	function automatic item_t flush_cmd();
		logic [95:0] noise;
		item_t it;
		noise = {$urandom, $urandom, $urandom};
		it = noise[$bits(item_t)-1:0];
		it.operation = OP_FLUSH;
		return it;
	endfunction

	// Queue a stretch of traffic: mostly jobs on a rising timeline, some strays and flushes.
	task automatic plan_traffic(input int n);
		int unsigned roll;
		int unsigned run;
		int unsigned dl;
		int unsigned back;
		if (free_at < 25'h0C00000)
			timeline = free_at + $urandom_range(0, 24'h1FFFFF);
		else
			timeline = free_at;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				queue_item(flush_cmd());
			end else if (roll < 14) begin
				// Stray job: arrives out of order with an arbitrary deadline.
				back = $urandom_range(0, (timeline < 800) ? timeline : 800);
				run = ($urandom_range(0, 3) == 0) ? ($urandom & 16'hFFFF)
					: $urandom_range(0, 300);
				queue_item(job(ID_W'($urandom), TIME_W'(timeline - back), TIME_W'(run),
					TIME_W'($urandom)));
			end else begin
				if (roll < 20)
					timeline += $urandom_range(200, 2500);
				else
					timeline += $urandom_range(0, 40);
				run = $urandom_range(0, 90);
				roll = $urandom_range(0, 99);
				if (roll < 55)
					dl = timeline + run + $urandom_range(0, 400);
				else if (roll < 85)
					dl = timeline + run + $urandom_range(0, 60);
				else if (roll < 95)
					dl = timeline + $urandom_range(0, run);
				else
					dl = timeline - $urandom_range(0, (timeline < 50) ? timeline : 50);
				queue_item(job(ID_W'($urandom), TIME_W'(timeline), TIME_W'(run),
					TIME_W'(dl)));
			end
		end
	endtask

	// Wait for every job to be taken and every result to arrive, then let the block go idle.
	task automatic settle();
		do
			@(posedge clk);
		while (job_feed.size() != 0 || start || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	task automatic flag_mismatch(input string what, input result_t want, input result_t got);
		miscompares++;
		if (miscompares <= 10) begin
			$display("%0t: %s: expected id %h ab %b fin %h wait %h last %b",
				$time, what, want.done_id, want.aborted, want.finish_time,
				want.wait_time, want.last_result);
			$display("%0t: %s: actual   id %h ab %b fin %h wait %h last %b",
				$time, what, got.done_id, got.aborted, got.finish_time,
				got.wait_time, got.last_result);
		end
	endtask

	// Driver: predict each accepted beat, then offer the next job unless idling.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else begin
			if (start && !busy)
				serve_item(item);
			if (!start || !busy) begin
				if (job_feed.size() != 0 && (steady || $urandom_range(0, 99) >= 16)) begin
					start <= 1'b1;
					item <= job_feed.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result beat must match the oldest expectation, field by field.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid) begin
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected result", '0, result);
			end else begin
				want = due_results.pop_front();
				if (result.done_id !== want.done_id || result.aborted !== want.aborted
						|| result.finish_time !== want.finish_time
						|| result.wait_time !== want.wait_time
						|| result.last_result !== want.last_result)
					flag_mismatch("result mismatch", want, result);
			end
		end
	end

	// Watchdog: give up when no beat of any kind has moved for too long.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [LIMIT_W-1:0] limits [8];
		logic [LTIME_W-1:0] f;
		limits = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd4, 4'd2, 4'd9, 4'd3};
		limits[4] = LIMIT_W'($urandom_range(2, 7));
		limits[7] = LIMIT_W'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed jobs under the reset limit: starts, queueing, drops, all drain outcomes.
		queue_item(job(16'h0000, 0, 0, 0));
		queue_item(job(16'hFFFF, 10, 100, 200));
		queue_item(job(16'h0003, 20, 50, 300));
		queue_item(job(16'h0004, 30, 10, 100));
		queue_item(job(16'h0005, 40, 60, 250));
		queue_item(job(16'h0006, 50, 1, 1000));
		queue_item(job(16'h0007, 120, 5, 500));
		queue_item(job(16'h0008, 400, 20, 900));
		queue_item(job(16'h0009, 405, 100, 450));
		queue_item(job(16'h000A, 406, 1, 10));
		queue_item(flush_cmd());
		queue_item(flush_cmd());
		queue_item(job(16'h000D, 100, 0, 0));
		queue_item(job(16'h000E, 101, 24'h00FFFF, 300));
		queue_item(job(16'h000F, 102, 3, 24'h00FFFF));
		queue_item(flush_cmd());
		settle();

		// Random phases, each under its own queue limit; the second runs without idling.
		for (int p = 0; p < 8; p++) begin
			write_limit(limits[p]);
			steady = (p == 1);
			plan_traffic(PHASE_ITEMS);
			settle();
		end
		steady = 1'b0;

		// Largest times and run lengths last, since they push the free time to its top.
		write_limit(4'd8);
		f = free_at;
		queue_item(job(16'h0001, f[TIME_W-1:0], 24'hFFFFFF, 24'hFFFFFF));
		queue_item(job(16'h0002, 0, 24'hFFFFFF, 0));
		queue_item(job(16'h0003, 24'h800000, 24'hFFFFFF, 24'hFFFFFF));
		queue_item(job(16'h0004, 24'hFFFFFF, 0, 24'hFFFFFF));
		queue_item(flush_cmd());
		queue_item(job(16'h0005, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
		queue_item(job(16'h0006, 24'hFFFFFF, 24'h7FFFFF, 24'h800000));
		queue_item(flush_cmd());
		settle();

		if (miscompares == 0 && due_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
src/bfjs_pkg.sv
src/bfjs_front.sv
src/bfjs_back.sv
src/bounded_fifo_job_server_unit.sv
dv/bounded_fifo_job_server_unit_test.sv
